@@ hdl/c2u_pkg.sv @@
package c2u_pkg;

   // Input transaction: one Windows-1251 code byte and the end-of-string flag.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_end;
   } req_type;

   // Result transaction: one UTF-8 byte with its flags.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       out_end;
   } rsp_type;

   // One decoded input byte: up to three UTF-8 bytes, emitted from index 0 up.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            byte_valid;
      logic            end_flag;
   } run_type;

   localparam int unsigned MapDepth = 128;

   // Upper half of the code page. Each word holds the UTF-8 sequence low byte
   // first; a zero top byte means a two-byte sequence, a zero word means no
   // mapping.
   localparam logic [23:0] W1251_MAP [MapDepth] = '{
      24'h0082D0, 24'h0083D0, 24'h9A80E2, 24'h0093D1,
      24'h9E80E2, 24'hA680E2, 24'hA080E2, 24'hA180E2,
      24'hAC82E2, 24'hB080E2, 24'h0089D0, 24'hB980E2,
      24'h008AD0, 24'h008CD0, 24'h008BD0, 24'h008FD0,
      24'h0092D1, 24'h9880E2, 24'h9980E2, 24'h9C80E2,
      24'h9D80E2, 24'hA280E2, 24'h9380E2, 24'h9480E2,
      24'h000000, 24'hA284E2, 24'h0099D1, 24'hBA80E2,
      24'h009AD1, 24'h009CD1, 24'h009BD1, 24'h009FD1,
      24'h00A0C2, 24'h008ED0, 24'h009ED1, 24'h0088D0,
      24'h00A4C2, 24'h0090D2, 24'h00A6C2, 24'h00A7C2,
      24'h0081D0, 24'h00A9C2, 24'h0084D0, 24'h00ABC2,
      24'h00ACC2, 24'h00ADC2, 24'h00AEC2, 24'h0087D0,
      24'h00B0C2, 24'h00B1C2, 24'h0086D0, 24'h0096D1,
      24'h0091D2, 24'h00B5C2, 24'h00B6C2, 24'h00B7C2,
      24'h0091D1, 24'h9684E2, 24'h0094D1, 24'h00BBC2,
      24'h0098D1, 24'h0085D0, 24'h0095D1, 24'h0097D1,
      24'h0090D0, 24'h0091D0, 24'h0092D0, 24'h0093D0,
      24'h0094D0, 24'h0095D0, 24'h0096D0, 24'h0097D0,
      24'h0098D0, 24'h0099D0, 24'h009AD0, 24'h009BD0,
      24'h009CD0, 24'h009DD0, 24'h009ED0, 24'h009FD0,
      24'h00A0D0, 24'h00A1D0, 24'h00A2D0, 24'h00A3D0,
      24'h00A4D0, 24'h00A5D0, 24'h00A6D0, 24'h00A7D0,
      24'h00A8D0, 24'h00A9D0, 24'h00AAD0, 24'h00ABD0,
      24'h00ACD0, 24'h00ADD0, 24'h00AED0, 24'h00AFD0,
      24'h00B0D0, 24'h00B1D0, 24'h00B2D0, 24'h00B3D0,
      24'h00B4D0, 24'h00B5D0, 24'h00B6D0, 24'h00B7D0,
      24'h00B8D0, 24'h00B9D0, 24'h00BAD0, 24'h00BBD0,
      24'h00BCD0, 24'h00BDD0, 24'h00BED0, 24'h00BFD0,
      24'h0080D1, 24'h0081D1, 24'h0082D1, 24'h0083D1,
      24'h0084D1, 24'h0085D1, 24'h0086D1, 24'h0087D1,
      24'h0088D1, 24'h0089D1, 24'h008AD1, 24'h008BD1,
      24'h008CD1, 24'h008DD1, 24'h008ED1, 24'h008FD1
   };

endpackage

@@ hdl/c2u_decoder.sv @@
module c2u_decoder
   import c2u_pkg::*;
(
   input  req_type req_i,
   output run_type run_o
);

   logic [23:0] word;

   always_comb begin
      word             = W1251_MAP[req_i.in_byte[6:0]];
      run_o.bytes      = '0;
      run_o.count      = 2'd1;
      run_o.byte_valid = 1'b1;
      run_o.end_flag   = req_i.in_end;
      if (!req_i.in_byte[7]) begin
         // ASCII passes straight through.
         run_o.bytes[0] = req_i.in_byte;
      end else if (word == 24'h0) begin
         // Unmapped code: a single empty result.
         run_o.byte_valid = 1'b0;
      end else begin
         run_o.bytes[0] = word[7:0];
         run_o.bytes[1] = word[15:8];
         run_o.bytes[2] = word[23:16];
         run_o.count    = (word[23:16] != 8'h0) ? 2'd3 : 2'd2;
      end
   end

endmodule

@@ hdl/c2u_serializer.sv @@
module c2u_serializer
   import c2u_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    run_valid,
   input  run_type run_i,
   output logic    take,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   logic    run_vld_ff, run_vld_in;
   run_type run_ff, run_in;
   logic [1:0] idx_ff, idx_in;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;
   logic    last;
   logic    free;

   always_comb begin
      last = (idx_ff == (run_ff.count - 2'd1));
      free = !run_vld_ff || last;
      take = free && run_valid;

      run_vld_in = run_vld_ff;
      run_in     = run_ff;
      idx_in     = idx_ff;
      if (take) begin
         run_vld_in = 1'b1;
         run_in     = run_i;
         idx_in     = 2'd0;
      end else if (run_vld_ff && last) begin
         run_vld_in = 1'b0;
      end else if (run_vld_ff) begin
         idx_in = idx_ff + 2'd1;
      end

      rsp_vld_in          = run_vld_ff;
      rsp_in.out_byte     = run_ff.bytes[idx_ff];
      rsp_in.byte_valid   = run_ff.byte_valid;
      rsp_in.run_last     = last;
      rsp_in.out_end      = run_ff.end_flag && last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         idx_ff     <= 2'd0;
      end else begin
         run_vld_ff <= run_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         idx_ff     <= idx_in;
      end
      run_ff <= run_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_item   = rsp_ff;

endmodule

@@ hdl/cp1251_to_utf8_transcoder_unit.sv @@
// Windows-1251 to UTF-8 transcoder.
//
// The user offers one code byte with its end-of-string flag on req_item and
// raises start; the transaction is taken at a rising edge where start is high
// and busy is low. Every code byte yields one to three result transactions on
// rsp_item, each shown for exactly one cycle with rsp_strobe high: ASCII gives
// one byte, Cyrillic and punctuation codes give two or three UTF-8 bytes, and
// the unmapped code 0x98 gives a single result with byte_valid clear. The last
// result of each run has run_last set and carries the end-of-string flag.
//
// A taken byte moves from the input register through the decoder into
// the run register, and its results leave through the result register.
// Throughput is one result per cycle while runs are waiting, set by the single
// output byte lane: one input byte a cycle for ASCII text; the next byte after
// a multi-byte character is held in the input register, and busy rises only
// while the held byte waits for the output lane to finish the previous run.
// The receiver cannot stall: results are never held back. A synchronous reset
// empties the input register and the output run; nothing else is kept, so the
// block is ready in the cycle after reset falls.
module cp1251_to_utf8_transcoder_unit
   import c2u_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   // Input register: holds one accepted transaction until the serialiser
   // takes its decoded run.
   logic    in_vld_ff, in_vld_in;
   req_type in_ff, in_in;
   run_type run;
   logic    take;
   logic    accept;

   always_comb begin
      busy      = in_vld_ff && !take;
      accept    = start && !busy;
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (accept) begin
         in_vld_in = 1'b1;
         in_in     = req_item;
      end else if (take) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      in_ff <= in_in;
   end

   // Table lookup between the input register and the run register.
   c2u_decoder u_decoder (
      .req_i (in_ff),
      .run_o (run)
   );

   // Emits the run one byte per cycle through the result register.
   c2u_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .run_valid  (in_vld_ff),
      .run_i      (run),
      .take       (take),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

@@ tb/tb_cp1251_to_utf8_transcoder_unit.sv @@
module tb_cp1251_to_utf8_transcoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import c2u_pkg::*;

   // Run limits. The watchdog trips when no transaction has moved on either
   // side for IdleLimit cycles. The slowest correct gap is the longest sender
   // pause on top of a three-byte run, so this is generous.
   localparam int unsigned MaxReported  = 10;
   localparam int unsigned IdleLimit    = 500;
   localparam int unsigned SettleCycles = 8;
   localparam int unsigned RandomItems  = 207;

   // UTF-8 encodings of the upper half of the Windows-1251 code page, packed
   // low byte first. A zero top byte marks a two-byte sequence and a zero
   // word marks the one code point that has no mapping.
   localparam logic [23:0] CP1251_UPPER_UTF8 [128] = '{
      24'h0082D0, 24'h0083D0, 24'h9A80E2, 24'h0093D1,
      24'h9E80E2, 24'hA680E2, 24'hA080E2, 24'hA180E2,
      24'hAC82E2, 24'hB080E2, 24'h0089D0, 24'hB980E2,
      24'h008AD0, 24'h008CD0, 24'h008BD0, 24'h008FD0,
      24'h0092D1, 24'h9880E2, 24'h9980E2, 24'h9C80E2,
      24'h9D80E2, 24'hA280E2, 24'h9380E2, 24'h9480E2,
      24'h000000, 24'hA284E2, 24'h0099D1, 24'hBA80E2,
      24'h009AD1, 24'h009CD1, 24'h009BD1, 24'h009FD1,
      24'h00A0C2, 24'h008ED0, 24'h009ED1, 24'h0088D0,
      24'h00A4C2, 24'h0090D2, 24'h00A6C2, 24'h00A7C2,
      24'h0081D0, 24'h00A9C2, 24'h0084D0, 24'h00ABC2,
      24'h00ACC2, 24'h00ADC2, 24'h00AEC2, 24'h0087D0,
      24'h00B0C2, 24'h00B1C2, 24'h0086D0, 24'h0096D1,
      24'h0091D2, 24'h00B5C2, 24'h00B6C2, 24'h00B7C2,
      24'h0091D1, 24'h9684E2, 24'h0094D1, 24'h00BBC2,
      24'h0098D1, 24'h0085D0, 24'h0095D1, 24'h0097D1,
      24'h0090D0, 24'h0091D0, 24'h0092D0, 24'h0093D0,
      24'h0094D0, 24'h0095D0, 24'h0096D0, 24'h0097D0,
      24'h0098D0, 24'h0099D0, 24'h009AD0, 24'h009BD0,
      24'h009CD0, 24'h009DD0, 24'h009ED0, 24'h009FD0,
      24'h00A0D0, 24'h00A1D0, 24'h00A2D0, 24'h00A3D0,
      24'h00A4D0, 24'h00A5D0, 24'h00A6D0, 24'h00A7D0,
      24'h00A8D0, 24'h00A9D0, 24'h00AAD0, 24'h00ABD0,
      24'h00ACD0, 24'h00ADD0, 24'h00AED0, 24'h00AFD0,
      24'h00B0D0, 24'h00B1D0, 24'h00B2D0, 24'h00B3D0,
      24'h00B4D0, 24'h00B5D0, 24'h00B6D0, 24'h00B7D0,
      24'h00B8D0, 24'h00B9D0, 24'h00BAD0, 24'h00BBD0,
      24'h00BCD0, 24'h00BDD0, 24'h00BED0, 24'h00BFD0,
      24'h0080D1, 24'h0081D1, 24'h0082D1, 24'h0083D1,
      24'h0084D1, 24'h0085D1, 24'h0086D1, 24'h0087D1,
      24'h0088D1, 24'h0089D1, 24'h008AD1, 24'h008BD1,
      24'h008CD1, 24'h008DD1, 24'h008ED1, 24'h008FD1
   };

   // Every input of the block has a known value from time zero onwards.
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // UTF-8 bytes still owed by the block, oldest at the front.
   rsp_type utf8_expected_q[$];

   // When clear, the sender offers every code byte without a pause.
   bit gaps_on = 1'b1;

   int unsigned error_count   = 0;
   int unsigned codes_sent    = 0;
   int unsigned results_seen  = 0;
   int unsigned ascii_codes   = 0;
   int unsigned two_byte_codes   = 0;
   int unsigned three_byte_codes = 0;
   int unsigned unmapped_codes   = 0;

   cp1251_to_utf8_transcoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   // Appends one owed result transaction at the back of the queue.
   function automatic void owe_byte(input rsp_type item);
      utf8_expected_q = {utf8_expected_q, item};
   endfunction

   // Works out the UTF-8 result transactions that one accepted code byte must
   // produce and queues them. Only the final byte of each run carries the
   // run marker and the end-of-string flag.
   function automatic void expand_code_byte(input req_type code);
      logic [23:0] word;
      if (!code.in_byte[7]) begin
         // Plain ASCII, the zero byte included, passes straight through.
         owe_byte(rsp_type'{code.in_byte, 1'b1, 1'b1, code.in_end});
         ascii_codes++;
         return;
      end
      word = CP1251_UPPER_UTF8[code.in_byte[6:0]];
      if (word == 24'h0) begin
         // The unmapped code yields a single empty result.
         owe_byte(rsp_type'{8'h00, 1'b0, 1'b1, code.in_end});
         unmapped_codes++;
         return;
      end
      owe_byte(rsp_type'{word[7:0], 1'b1, 1'b0, 1'b0});
      if (word[23:16] == 8'h00) begin
         owe_byte(rsp_type'{word[15:8], 1'b1, 1'b1, code.in_end});
         two_byte_codes++;
      end else begin
         owe_byte(rsp_type'{word[15:8], 1'b1, 1'b0, 1'b0});
         owe_byte(rsp_type'{word[23:16], 1'b1, 1'b1, code.in_end});
         three_byte_codes++;
      end
   endfunction

   task automatic report_bad(input string why, input rsp_type want, input rsp_type got);
      if (error_count < MaxReported) begin
         $display("%0t ns: %s: expected byte %h valid %b last %b end %b, "
                  , $time, why, want.out_byte, want.byte_valid, want.run_last
                  , want.out_end);
         $display("         got byte %h valid %b last %b end %b"
                  , got.out_byte, got.byte_valid, got.run_last, got.out_end);
      end
      error_count++;
   endtask

   // Offers one code byte. The optional pause is drawn before the byte goes
   // out, with start low for the whole pause, so that gaps land on every
   // phase of the run in progress. Everything changes at the falling edge and
   // the handshake is judged at the rising edge, so there is no race.
   task automatic send_code(input logic [7:0] code_byte, input logic end_flag);
      int unsigned gap;
      req_type     code;
      code.in_byte = code_byte;
      code.in_end  = end_flag;
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= code;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      // The transaction was taken at this edge.
      expand_code_byte(code);
      codes_sent++;
   endtask

   // Holds the sender off until every UTF-8 byte owed has come out.
   task automatic wait_for_drain;
      @(negedge clock);
      start <= 1'b0;
      while (utf8_expected_q.size() != 0)
         @(posedge clock);
   endtask

   // The extremes of the ASCII range, including the zero byte, which must
   // pass through like any other.
   task automatic test_ascii_passthrough;
      send_code(8'h00, 1'b0);
      send_code(8'h01, 1'b0);
      send_code(8'h7F, 1'b0);
      send_code(8'h41, 1'b1);
   endtask

   // Codes that become two UTF-8 bytes, at both ends of the upper half.
   task automatic test_two_byte_codes;
      send_code(8'h80, 1'b0);
      send_code(8'hA0, 1'b0);
      send_code(8'hC0, 1'b0);
      send_code(8'hFF, 1'b1);
   endtask

   // Punctuation and symbols that become three UTF-8 bytes, among them the
   // trade mark and numero signs.
   task automatic test_three_byte_codes;
      send_code(8'h82, 1'b0);
      send_code(8'h85, 1'b0);
      send_code(8'h99, 1'b0);
      send_code(8'hB9, 1'b1);
   endtask

   // The unmapped code, with the end flag clear and set, then a plain byte to
   // show the block carries on normally.
   task automatic test_unmapped_code;
      send_code(8'h98, 1'b0);
      send_code(8'h98, 1'b1);
      send_code(8'h41, 1'b0);
   endtask

   // Every kind of code offered without pauses, so that busy has to hold the
   // sender off while the longer runs drain.
   task automatic test_back_to_back;
      gaps_on = 1'b0;
      send_code(8'h82, 1'b0);
      send_code(8'h98, 1'b0);
      send_code(8'h41, 1'b0);
      send_code(8'hC0, 1'b0);
      send_code(8'h7F, 1'b1);
      gaps_on = 1'b1;
   endtask

   // The sender stops in the middle of a string until the block is empty and
   // then finishes the string.
   task automatic test_drain_pause;
      send_code(8'hE0, 1'b0);
      send_code(8'h96, 1'b0);
      wait_for_drain();
      send_code(8'h41, 1'b1);
   endtask

   // Mostly well-formed strings: mixed ASCII, Cyrillic letters and the other
   // upper-half codes, with the end flag on the final byte only. The rest is
   // noise with any byte value and a random end flag. Some strings go out
   // without pauses, and now and then the sender waits for the block to drain.
   task automatic test_random_strings;
      int unsigned sent;
      int unsigned length;
      int unsigned pick;
      logic [7:0]  code_byte;
      sent = 0;
      while (sent < RandomItems) begin
         gaps_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 9) < 8) begin
            length = $urandom_range(1, 12);
            for (int unsigned i = 0; i < length; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 40)
                  code_byte = 8'($urandom_range(1, 127));
               else if (pick < 80)
                  code_byte = 8'($urandom_range(192, 255));
               else if (pick < 97)
                  code_byte = 8'($urandom_range(128, 191));
               else
                  code_byte = 8'h98;
               send_code(code_byte, i == length - 1);
            end
            sent += length;
         end else begin
            length = $urandom_range(1, 6);
            for (int unsigned i = 0; i < length; i++)
               send_code(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent += length;
         end
         if ($urandom_range(0, 5) == 0)
            wait_for_drain();
      end
      gaps_on = 1'b1;
   endtask

   // Compares every result transaction with the oldest one owed. The block
   // cannot be held off, so each strobe cycle is one transaction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            results_seen++;
            if (utf8_expected_q.size() == 0) begin
               report_bad("result with none owed", '0, rsp_item);
            end else begin
               want = utf8_expected_q.pop_front();
               if (rsp_item.out_byte   !== want.out_byte   ||
                   rsp_item.byte_valid !== want.byte_valid ||
                   rsp_item.run_last   !== want.run_last   ||
                   rsp_item.out_end    !== want.out_end) begin
                  report_bad("result mismatch", want, rsp_item);
               end
            end
         end else if (rsp_strobe !== 1'b0) begin
            report_bad("strobe unknown", '0, rsp_item);
         end
      end
   end

   // Watchdog: counts cycles in which no transaction moves on either side.
   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || rsp_strobe === 1'b1 || (start === 1'b1 && busy === 1'b0))
            quiet = 0;
         else
            quiet++;
         if (quiet == IdleLimit) begin
            $display("Watchdog: no transaction for %0d cycles.", IdleLimit);
            $display("tb_cp1251_to_utf8_transcoder_unit: done, errors");
            $finish;
         end
      end
   end

   initial begin
      // Reset is held from time zero and released at a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ascii_passthrough();
      test_two_byte_codes();
      test_three_byte_codes();
      test_unmapped_code();
      test_back_to_back();
      test_drain_pause();
      test_random_strings();

      // Let the last run finish, then allow a settling time for any stray result.
      wait_for_drain();
      repeat (SettleCycles) @(posedge clock);
      while (utf8_expected_q.size() != 0)
         report_bad("result never came", utf8_expected_q.pop_front(), '0);

      $display("Sent %0d code bytes: %0d ASCII, %0d two-byte, %0d three-byte, %0d unmapped.",
               codes_sent, ascii_codes, two_byte_codes, three_byte_codes, unmapped_codes);
      $display("Checked %0d UTF-8 result transactions, %0d failures.",
               results_seen, error_count);
      if (error_count == 0)
         $display("tb_cp1251_to_utf8_transcoder_unit: done, clean");
      else
         $display("tb_cp1251_to_utf8_transcoder_unit: done, errors");
      $finish;
   end

endmodule
